### rtl/rsq_pkg.sv
// Shared types and constants for the binary32 reciprocal square root core.
// Used by rsq_prep, rsq_cell, rsq_round and the top level.
package rsq_pkg;

  localparam int unsigned QBits = 26;
  localparam int unsigned MBits = 25;
  localparam int unsigned YBits = 51;
  localparam int unsigned RBits = 75;

  localparam logic [31:0] ExpMask  = 32'h7F80_0000;
  localparam logic [31:0] FracMask = 32'h007F_FFFF;
  localparam logic [31:0] QuietBit = 32'h0040_0000;
  localparam logic [31:0] PosInf   = 32'h7F80_0000;
  localparam logic [31:0] NegInf   = 32'hFF80_0000;
  localparam logic [31:0] QNan     = 32'h7FC0_0000;
  localparam logic [31:0] PosZero  = 32'h0000_0000;
  localparam logic [8:0]  ExpBias  = 9'd113;

  typedef struct packed {
    logic                     special;
    logic [31:0]              spec_val;
    logic signed [7:0]        half_exp;
    logic [MBits-1:0]         mant;
    logic [YBits-1:0]         qm;
    logic [RBits-1:0]         rem;
    logic [QBits-1:0]         q;
  } rsq_word_t;

endpackage

### rtl/rsq_prep.sv
// Input stage: decode special values and normalize the operand.
// Depends on rsq_pkg.
module rsq_prep (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  logic [31:0]        operand,
  output logic               dn_valid,
  input  logic               dn_ready,
  output rsq_pkg::rsq_word_t dn_word
);

  logic               v_r, v_nxt;
  rsq_pkg::rsq_word_t w_r, w_nxt;
  logic [7:0]         ef;
  logic [23:0]        frac24;
  logic [4:0]         lz;
  logic [23:0]        mant24;
  logic signed [9:0]  e;
  logic [24:0]        m25;
  logic signed [9:0]  e_even;

  assign up_ready = !v_r || dn_ready;
  assign ef       = operand[30:23];
  assign frac24   = {1'b0, operand[22:0]};

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (frac24[i]) begin
        lz = 5'(23 - i);
      end
    end
  end

  always_comb begin
    if (ef != 8'd0) begin
      mant24 = {1'b1, operand[22:0]};
      e      = $signed({2'b00, ef}) - 10'sd150;
    end else begin
      mant24 = frac24 << lz;
      e      = -10'sd149 - $signed({5'd0, lz});
    end
    if (e[0]) begin
      m25    = {mant24, 1'b0};
      e_even = e - 10'sd1;
    end else begin
      m25    = {1'b0, mant24};
      e_even = e;
    end
  end

  always_comb begin
    w_nxt          = w_r;
    w_nxt.special  = (operand >= rsq_pkg::ExpMask) || (operand == 32'd0);
    w_nxt.half_exp = 8'(e_even >>> 1);
    w_nxt.mant     = w_nxt.special ? 25'h080_0000 : m25;
    w_nxt.qm       = '0;
    w_nxt.rem      = {1'b1, 74'd0};
    w_nxt.q        = '0;
    if ((operand & 32'h7FFF_FFFF) == 32'd0) begin
      w_nxt.spec_val = (operand == 32'd0) ? rsq_pkg::PosInf : rsq_pkg::NegInf;
    end else if ((operand & rsq_pkg::ExpMask) == rsq_pkg::ExpMask &&
                 (operand & rsq_pkg::FracMask) != 32'd0) begin
      w_nxt.spec_val = operand | rsq_pkg::QuietBit;
    end else if (operand == rsq_pkg::PosInf) begin
      w_nxt.spec_val = rsq_pkg::PosZero;
    end else begin
      w_nxt.spec_val = rsq_pkg::QNan;
    end
  end

  assign v_nxt = up_ready ? up_valid : v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      w_r <= w_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_word  = w_r;

endmodule

### rtl/rsq_cell.sv
// One cell of the root chain: decides one bit of q = floor(2^37/sqrt(M)).
// Depends on rsq_pkg.
module rsq_cell #(
  parameter int unsigned BIT_POS = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  rsq_pkg::rsq_word_t up_word,
  output logic               dn_valid,
  input  logic               dn_ready,
  output rsq_pkg::rsq_word_t dn_word
);

  logic               v_r, v_nxt;
  rsq_pkg::rsq_word_t w_r, w_nxt;
  logic [77:0]        trial;
  logic               take;

  assign up_ready = !v_r || dn_ready;

  always_comb begin
    trial = ({27'd0, up_word.qm} << (BIT_POS + 1)) + ({53'd0, up_word.mant} << (2 * BIT_POS));
    take  = trial <= {3'd0, up_word.rem};
    w_nxt = up_word;
    if (take) begin
      w_nxt.rem = up_word.rem - trial[rsq_pkg::RBits-1:0];
      w_nxt.qm  = up_word.qm + ({26'd0, up_word.mant} << BIT_POS);
      w_nxt.q   = up_word.q | (rsq_pkg::QBits'(1) << BIT_POS);
    end
  end

  assign v_nxt = up_ready ? up_valid : v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      w_r <= w_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_word  = w_r;

endmodule

### rtl/rsq_round.sv
// Output stage: round q to 24 bits, build the binary32 word, hold it for the sink.
// Depends on rsq_pkg.
module rsq_round (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  rsq_pkg::rsq_word_t up_word,
  output logic               dn_valid,
  input  logic               dn_ready,
  output logic [31:0]        dn_bits
);

  logic        v_r, v_nxt;
  logic [31:0] res_r, res_nxt;
  logic        exact;
  logic        wide;
  logic [23:0] sig;
  logic        up;
  logic [24:0] sig_inc;
  logic [8:0]  biased;

  assign up_ready = !v_r || dn_ready;

  always_comb begin
    exact = up_word.rem == '0;
    wide  = up_word.q[25];
    if (wide) begin
      sig = up_word.q[25:2];
      up  = up_word.q[1] && (up_word.q[0] || !exact || sig[0]);
    end else begin
      sig = up_word.q[24:1];
      up  = up_word.q[0] && (!exact || sig[0]);
    end
    biased  = rsq_pkg::ExpBias + (wide ? 9'd2 : 9'd1) - 9'(up_word.half_exp);
    sig_inc = {1'b0, sig} + {24'd0, up};
    if (sig_inc[24]) begin
      biased = biased + 9'd1;
    end
    if (up_word.special) begin
      res_nxt = up_word.spec_val;
    end else begin
      res_nxt = {1'b0, biased[7:0], sig_inc[22:0]};
    end
  end

  assign v_nxt = up_ready ? up_valid : v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res_r <= res_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_bits  = res_r;

endmodule

### rtl/float32_reciprocal_sqrt_core.sv
// Binary32 reciprocal square root, correctly rounded to nearest-even.
// Depends on rsq_pkg, rsq_prep, rsq_cell and rsq_round.
//
// Usage: present an operand word on in_tdata with in_tvalid; it is taken when
// in_tready is high. The result word appears on out_tdata with out_tvalid and
// is held until out_tready is high. One result per operand, in order.
// Stages: decode stage, 26 root cells, round stage; each root cell fixes one
// bit of q. Throughput: one word per cycle while the output is not stalled.
// Each stage holds its word when the next one is full, so a stalled sink
// backs up the chain stage by stage; empty stages still take new words.
// Reset clears all stage valid flags; the core is empty after reset.
// Specials: +0 -> +inf, -0 -> -inf, NaN -> quieted NaN, +inf -> +0,
// negative nonzero -> 0x7FC00000.
module float32_reciprocal_sqrt_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] operand_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] result_bits
);

  localparam int unsigned NCell = rsq_pkg::QBits;

  logic               v   [NCell+1];
  logic               rdy [NCell+1];
  rsq_pkg::rsq_word_t w   [NCell+1];

  rsq_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .operand  (in_tdata),
    .dn_valid (v[0]),
    .dn_ready (rdy[0]),
    .dn_word  (w[0])
  );

  for (genvar k = 0; k < NCell; k++) begin : g_cell
    rsq_cell #(.BIT_POS(NCell - 1 - k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (v[k]),
      .up_ready (rdy[k]),
      .up_word  (w[k]),
      .dn_valid (v[k+1]),
      .dn_ready (rdy[k+1]),
      .dn_word  (w[k+1])
    );
  end

  rsq_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (v[NCell]),
    .up_ready (rdy[NCell]),
    .up_word  (w[NCell]),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_bits  (out_tdata)
  );

  a_no_subnormal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[30:23] == 8'd0 && out_tdata[22:0] != 23'd0))
    else $error("subnormal result");

  a_nan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[30:23] == 8'hFF && out_tdata[22:0] != 23'd0) |-> out_tdata[22])
    else $error("signaling NaN result");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

endmodule
